### rtl/sqep_pkg.sv
// Package for the quintic easing servo profile: register indexes, opcodes,
// the centre reset pulse and the units' shared control struct. No dependencies.
package sqep_pkg;

  localparam logic [2:0] RegPulseMin  = 3'd0;
  localparam logic [2:0] RegPulseMax  = 3'd1;
  localparam logic [2:0] RegAngleMax  = 3'd2;
  localparam logic [2:0] RegMsPerUs   = 3'd3;
  localparam logic [2:0] RegMinEase   = 3'd4;

  localparam logic OpSetTarget = 1'b0;
  localparam logic OpUpdate    = 1'b1;

  localparam logic [15:0] CentrePulse = 16'd1500;

  typedef struct packed {
    logic start;
    logic done;
  } ctl_t;

endpackage

### rtl/servo_quintic_easing_profile.sv
// Top level of the quintic easing servo profile generator.
// Depends on sqep_pkg, sqep_divider and sqep_multiplier.
//
// One request is taken when start_i is high and busy_o is low. A set-target
// request uses a 48-step divider for the angle mapping and two 32-step
// serial multiplications. An update request passes over idle servos,
// emits the goal of each servo that reaches it, and eases each moving
// servo with a 48-step serial divider for the progress and four 32-step
// serial multiplications.
// Each result appears for one cycle with result_valid_o; the receiver cannot
// stall, and last_o marks the final result of an update.
module servo_quintic_easing_profile #(
  parameter int unsigned NUM_SERVOS = 2,
  parameter int unsigned FRAC_BITS  = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic        opcode_i,
  input  logic [1:0]  servo_number_i,
  input  logic [15:0] target_angle_i,
  input  logic [31:0] now_ms_i,
  output logic        result_valid_o,
  output logic        servo_index_o,
  output logic [15:0] pulse_us_o,
  output logic        last_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);
  localparam int unsigned SW   = (NUM_SERVOS > 1) ? $clog2(NUM_SERVOS) : 1;
  localparam int unsigned DivW = 32 + FRAC_BITS;
  localparam int unsigned FW   = FRAC_BITS + 2;
  localparam int unsigned PW   = FRAC_BITS + 5;

  localparam logic [3:0] StIdle  = 4'd0;
  localparam logic [3:0] StMapD  = 4'd1;
  localparam logic [3:0] StDurM  = 4'd2;
  localparam logic [3:0] StScan  = 4'd3;
  localparam logic [3:0] StTDiv  = 4'd4;
  localparam logic [3:0] StT2    = 4'd5;
  localparam logic [3:0] StT3    = 4'd6;
  localparam logic [3:0] StF     = 4'd7;
  localparam logic [3:0] StDelta = 4'd8;
  localparam logic [3:0] StEmit  = 4'd9;
  localparam logic [3:0] StMapM  = 4'd10;

  logic [15:0] pmin_q, pmax_q, amax_q, mspu_q, mine_q;

  logic [NUM_SERVOS-1:0] mov_q;
  logic [15:0] cur_q  [NUM_SERVOS];
  logic [15:0] org_q  [NUM_SERVOS];
  logic [15:0] goal_q [NUM_SERVOS];
  logic [31:0] st_q   [NUM_SERVOS];
  logic [31:0] dur_q  [NUM_SERVOS];

  logic [3:0]    state_q;
  logic [SW-1:0] idx_q;
  logic [SW:0]   cnt_q;
  logic [31:0]   now_q;
  logic [15:0]   ang_q;
  logic [15:0]   goal_w_q;
  logic [FW-1:0] t_q, t2_q, t3_q, f_q;

  logic          div_go, mul_go;
  logic [DivW-1:0] div_num, div_quo;
  logic [31:0]   div_den;
  logic [31:0]   mul_a, mul_b;
  logic [63:0]   mul_p;
  sqep_pkg::ctl_t div_ctl, mul_ctl;

  sqep_divider #(.NumW(DivW), .DenW(32)) u_div (
    .clk_i, .rst_ni, .start_i(div_go), .num_i(div_num), .den_i(div_den),
    .ctl_o(div_ctl), .quo_o(div_quo));

  sqep_multiplier #(.AW(32), .BW(32)) u_mul (
    .clk_i, .rst_ni, .start_i(mul_go), .a_i(mul_a), .b_i(mul_b),
    .ctl_o(mul_ctl), .prod_o(mul_p));

  logic [15:0] span, ang_c, diffp, cur_s, org_s, gl_s;
  logic [31:0] elapsed, dur_s;
  logic [PW-1:0] pexp;
  logic          up;
  logic [15:0] mag;
  logic [31:0] dur_calc;
  logic        more;
  logic [SW:0] nxt;
  logic        kick;

  always_comb begin
    span  = (pmax_q < pmin_q || amax_q == '0) ? 16'd0 : pmax_q - pmin_q;
    ang_c = (ang_q > amax_q) ? amax_q : ang_q;
    cur_s = cur_q[idx_q];
    org_s = org_q[idx_q];
    gl_s  = goal_q[idx_q];
    dur_s = dur_q[idx_q];
    elapsed = now_q - st_q[idx_q];
    diffp = (goal_w_q > cur_s) ? goal_w_q - cur_s : cur_s - goal_w_q;
    up  = gl_s >= org_s;
    mag = up ? gl_s - org_s : org_s - gl_s;
    pexp = PW'(10) * (PW'(1) << FRAC_BITS) - PW'(15) * PW'(t_q) + PW'(6) * PW'(t2_q);
    if (pexp[PW-1]) pexp = '0;
    dur_calc = 32'(mul_p[39:8]);
    if (dur_calc < {16'd0, mine_q}) dur_calc = {16'd0, mine_q};
    nxt  = cnt_q + 1'b1;
    more = 1'b0;
    for (int i = 0; i < NUM_SERVOS; i++) begin
      if (i > int'(idx_q) && mov_q[i]) more = 1'b1;
    end
  end

  // The shared units start on the first cycle of a state that uses them.
  assign kick = (sub_q == 2'd0) && !(state_q == StTDiv && elapsed >= dur_s);

  always_comb begin
    div_go  = 1'b0;
    mul_go  = 1'b0;
    div_num = '0;
    div_den = '0;
    mul_a   = '0;
    mul_b   = '0;
    case (state_q)
      StMapM: begin
        mul_go = kick;
        mul_a = {16'd0, ang_c};
        mul_b = {16'd0, span};
      end
      StMapD: begin
        div_go = kick;
        div_num = DivW'(mul_p[31:0]);
        div_den = (amax_q == '0) ? 32'd1 : {16'd0, amax_q};
      end
      StDurM: begin
        mul_go = kick;
        mul_a = {16'd0, diffp};
        mul_b = {16'd0, mspu_q};
      end
      StTDiv: begin
        div_go = kick;
        div_num = {elapsed, {FRAC_BITS{1'b0}}};
        div_den = dur_s;
      end
      StT2: begin
        mul_go = kick;
        mul_a = 32'(t_q);
        mul_b = 32'(t_q);
      end
      StT3: begin
        mul_go = kick;
        mul_a = 32'(t2_q);
        mul_b = 32'(t_q);
      end
      StF: begin
        mul_go = kick;
        mul_a = 32'(t3_q);
        mul_b = 32'(pexp);
      end
      StDelta: begin
        mul_go = kick;
        mul_a = {16'd0, mag};
        mul_b = 32'(f_q);
      end
      default: ;
    endcase
  end

  logic [1:0] sub_q;
  logic [15:0] res_p;
  logic [63:0] fsh;
  logic [31:0] ddn;
  always_comb begin
    fsh = mul_p >> FRAC_BITS;
    ddn = 32'((mul_p + ((64'd1 << FRAC_BITS) - 64'd1)) >> FRAC_BITS);
    res_p = up ? 16'(32'(org_s) + 32'(fsh)) : 16'(32'(org_s) - ddn);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pmin_q <= 16'd500;
      pmax_q <= 16'd2500;
      amax_q <= 16'd2700;
      mspu_q <= 16'd256;
      mine_q <= 16'd50;
      mov_q  <= '0;
      for (int i = 0; i < NUM_SERVOS; i++) begin
        cur_q[i]  <= sqep_pkg::CentrePulse;
        org_q[i]  <= sqep_pkg::CentrePulse;
        goal_q[i] <= sqep_pkg::CentrePulse;
        st_q[i]   <= '0;
        dur_q[i]  <= '0;
      end
      state_q <= StIdle;
      sub_q   <= '0;
      idx_q   <= '0;
      cnt_q   <= '0;
      now_q   <= '0;
      ang_q   <= '0;
      goal_w_q <= '0;
      t_q     <= '0;
      t2_q    <= '0;
      t3_q    <= '0;
      f_q     <= '0;
      pulse_us_o <= '0;
      servo_index_o <= 1'b0;
      result_valid_o <= 1'b0;
      last_o <= 1'b0;
    end else begin
      result_valid_o <= (state_q == StEmit);
      last_o <= (state_q == StEmit) && !more;
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          sqep_pkg::RegPulseMin: pmin_q <= cfg_data_i;
          sqep_pkg::RegPulseMax: pmax_q <= cfg_data_i;
          sqep_pkg::RegAngleMax: amax_q <= cfg_data_i;
          sqep_pkg::RegMsPerUs:  mspu_q <= cfg_data_i;
          sqep_pkg::RegMinEase:  mine_q <= cfg_data_i;
          default: ;
        endcase
      end
      case (state_q)
        StIdle: begin
          sub_q <= '0;
          if (start_i) begin
            now_q <= now_ms_i;
            ang_q <= target_angle_i;
            if (opcode_i == sqep_pkg::OpUpdate) begin
              idx_q <= '0;
              cnt_q <= '0;
              state_q <= StScan;
            end else if (servo_number_i != 2'd0 &&
                         {1'b0, servo_number_i} <= 3'(NUM_SERVOS)) begin
              idx_q <= SW'(servo_number_i - 2'd1);
              state_q <= StMapM;
            end
          end
        end
        StMapM: begin
          if (sub_q == 2'd0) sub_q <= 2'd1;
          else if (mul_ctl.done) begin
            sub_q <= '0;
            state_q <= StMapD;
          end
        end
        StMapD: begin
          if (sub_q == 2'd0) sub_q <= 2'd1;
          else if (div_ctl.done) begin
            goal_w_q <= pmin_q + 16'(div_quo);
            sub_q <= '0;
            state_q <= StDurM;
          end
        end
        StDurM: begin
          if (sub_q == 2'd0) sub_q <= 2'd1;
          else if (mul_ctl.done) begin
            dur_q[idx_q]  <= dur_calc;
            org_q[idx_q]  <= cur_s;
            goal_q[idx_q] <= goal_w_q;
            st_q[idx_q]   <= now_q;
            mov_q[idx_q]  <= 1'b1;
            sub_q <= '0;
            state_q <= StIdle;
          end
        end
        StScan: begin
          if (cnt_q == (SW+1)'(NUM_SERVOS)) begin
            state_q <= StIdle;
          end else begin
            idx_q <= SW'(cnt_q);
            if (mov_q[SW'(cnt_q)]) begin
              state_q <= StTDiv;
            end else begin
              cnt_q <= nxt;
            end
          end
        end
        StTDiv: begin
          if (elapsed >= dur_s) begin
            cur_q[idx_q] <= gl_s;
            mov_q[idx_q] <= 1'b0;
            pulse_us_o <= gl_s;
            state_q <= StEmit;
          end else if (sub_q == 2'd0) sub_q <= 2'd1;
          else if (div_ctl.done) begin
            t_q <= FW'(div_quo);
            sub_q <= '0;
            state_q <= StT2;
          end
        end
        StT2: begin
          if (sub_q == 2'd0) sub_q <= 2'd1;
          else if (mul_ctl.done) begin
            t2_q <= FW'(fsh);
            sub_q <= '0;
            state_q <= StT3;
          end
        end
        StT3: begin
          if (sub_q == 2'd0) sub_q <= 2'd1;
          else if (mul_ctl.done) begin
            t3_q <= FW'(fsh);
            sub_q <= '0;
            state_q <= StF;
          end
        end
        StF: begin
          if (sub_q == 2'd0) sub_q <= 2'd1;
          else if (mul_ctl.done) begin
            f_q <= (fsh > (64'd1 << FRAC_BITS)) ? FW'(1) << FRAC_BITS : FW'(fsh);
            sub_q <= '0;
            state_q <= StDelta;
          end
        end
        StDelta: begin
          if (sub_q == 2'd0) sub_q <= 2'd1;
          else if (mul_ctl.done) begin
            cur_q[idx_q] <= res_p;
            pulse_us_o <= res_p;
            sub_q <= '0;
            state_q <= StEmit;
          end
        end
        StEmit: begin
          servo_index_o <= idx_q[0];
          cnt_q    <= nxt;
          state_q  <= StScan;
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  assign busy_o      = (state_q != StIdle);
  assign cfg_ready_o = 1'b1;

  a_last_with_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    last_o |-> result_valid_o) else $error("last without result");
  a_result_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o) else $error("results back to back");
  a_busy_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> busy_o) else $error("result while idle");
endmodule

### rtl/sqep_divider.sv
// Bit-serial restoring divider: one quotient bit per cycle.
// Depends on sqep_pkg for the control struct.
module sqep_divider #(
  parameter int unsigned NumW = 48,
  parameter int unsigned DenW = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [NumW-1:0]     num_i,
  input  logic [DenW-1:0]     den_i,
  output sqep_pkg::ctl_t      ctl_o,
  output logic [NumW-1:0]     quo_o
);
  localparam int unsigned CntW = $clog2(NumW + 1);

  logic [NumW-1:0] quo_q, quo_d;
  logic [DenW-1:0] rem_q, rem_d;
  logic [DenW-1:0] den_q, den_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            busy_q, busy_d, done_q, done_d;
  logic [DenW:0]   trial;
  logic [DenW+1:0] diff;

  always_comb begin
    quo_d  = quo_q;
    rem_d  = rem_q;
    den_d  = den_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    trial  = {rem_q, quo_q[NumW-1]};
    diff   = {1'b0, trial} - {2'b00, den_q};
    if (start_i) begin
      quo_d  = num_i;
      rem_d  = '0;
      den_d  = den_i;
      cnt_d  = CntW'(NumW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (!diff[DenW+1]) begin
        rem_d = diff[DenW-1:0];
        quo_d = {quo_q[NumW-2:0], 1'b1};
      end else begin
        rem_d = trial[DenW-1:0];
        quo_d = {quo_q[NumW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign ctl_o.start = busy_q;
  assign ctl_o.done  = done_q;
  assign quo_o       = quo_q;

  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(busy_q)) else $error("divider done without work");
  a_busy_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> cnt_q != '0) else $error("divider count ran out while busy");
  a_no_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy_q) else $error("divider busy and done together");
endmodule

### rtl/sqep_multiplier.sv
// Bit-serial shift-and-add multiplier: one multiplier bit per cycle.
// Depends on sqep_pkg for the control struct.
module sqep_multiplier #(
  parameter int unsigned AW = 32,
  parameter int unsigned BW = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [AW-1:0]     a_i,
  input  logic [BW-1:0]     b_i,
  output sqep_pkg::ctl_t    ctl_o,
  output logic [AW+BW-1:0]  prod_o
);
  localparam int unsigned CntW = $clog2(BW + 1);

  logic [AW+BW-1:0] acc_q, acc_d;
  logic [AW-1:0]    a_q, a_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             busy_q, busy_d, done_q, done_d;
  logic [AW:0]      hi;

  always_comb begin
    acc_d  = acc_q;
    a_d    = a_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    hi     = {1'b0, acc_q[AW+BW-1:BW]} + (acc_q[0] ? {1'b0, a_q} : '0);
    if (start_i) begin
      acc_d  = {{AW{1'b0}}, b_i};
      a_d    = a_i;
      cnt_d  = CntW'(BW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      acc_d = {hi, acc_q[BW-1:1]};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    a_q   <= a_d;
  end

  assign ctl_o.start = busy_q;
  assign ctl_o.done  = done_q;
  assign prod_o      = acc_q;

  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(busy_q)) else $error("multiplier done without work");
  a_busy_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> cnt_q != '0) else $error("multiplier count ran out");
  a_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy_q) else $error("multiplier busy and done together");
endmodule

### verif/tb_servo_quintic_easing_profile.sv
// Testbench for servo_quintic_easing_profile: drives set-target and update
// requests, predicts the eased pulse results and checks each one.
// Depends on sqep_pkg and the RTL of the profile generator.
module tb_servo_quintic_easing_profile;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NServo = 2;
  localparam int unsigned FracBits = 16;
  localparam longint unsigned MaxCycles = 4000000;

  typedef struct packed {
    logic        idx;
    logic [15:0] pulse;
    logic        last;
  } pulse_res_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start_i = 1'b0;
  logic opcode_i = 1'b0;
  logic [1:0] servo_number_i = '0;
  logic [15:0] target_angle_i = '0;
  logic [31:0] now_ms_i = '0;
  logic cfg_valid_i = 1'b0;
  logic [2:0] cfg_index_i = '0;
  logic [15:0] cfg_data_i = '0;
  logic busy_o, result_valid_o, servo_index_o, last_o, cfg_ready_o;
  logic [15:0] pulse_us_o;

  servo_quintic_easing_profile i_dut (
    .clk_i, .rst_ni, .start_i, .busy_o, .opcode_i, .servo_number_i,
    .target_angle_i, .now_ms_i, .result_valid_o, .servo_index_o, .pulse_us_o,
    .last_o, .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  logic [15:0] r_pmin, r_pmax, r_amax, r_rate, r_mine;
  logic        s_moving [NServo];
  logic [15:0] s_cur [NServo];
  logic [15:0] s_org [NServo];
  logic [15:0] s_goal [NServo];
  logic [31:0] s_t0 [NServo];
  logic [31:0] s_dur [NServo];

  pulse_res_t pulse_q[$];
  int unsigned n_err = 0;
  int unsigned n_res = 0;
  int unsigned n_req = 0;
  int unsigned idle_pct = 0;
  longint unsigned cycle_cnt = 0;
  logic [31:0] clock_ms = '0;

  task automatic report(input string msg);
    $display("%0t ERROR %s", $time, msg);
    n_err++;
  endtask

  function automatic logic [15:0] map_angle(input logic [15:0] ang);
    logic [15:0] a;
    logic [63:0] prod;
    a = (ang > r_amax) ? r_amax : ang;
    if (r_amax == 0 || r_pmax < r_pmin) return r_pmin;
    prod = 64'(a) * 64'(r_pmax - r_pmin);
    return r_pmin + 16'(prod / r_amax);
  endfunction

  function automatic logic [15:0] eased(input int s, input logic [31:0] el);
    longint unsigned t, t2, t3, f, o, g, mask;
    longint p, one;
    one = longint'(1) << FracBits;
    t = (longint'(el) << FracBits) / s_dur[s];
    t2 = (t * t) >> FracBits;
    t3 = (t2 * t) >> FracBits;
    p = 10 * one - 15 * longint'(t) + 6 * longint'(t2);
    if (p < 0) p = 0;
    f = (t3 * longint'(p)) >> FracBits;
    if (f > one) f = one;
    o = s_org[s];
    g = s_goal[s];
    mask = one - 1;
    if (g >= o) return 16'(o + (((g - o) * f) >> FracBits));
    return 16'(o - ((((o - g) * f) + mask) >> FracBits));
  endfunction

  task automatic predict_request(input logic op, input logic [1:0] num,
                                 input logic [15:0] ang, input logic [31:0] now);
    int s, cnt;
    logic [15:0] goal;
    logic [31:0] diff, dur, el;
    pulse_res_t r;
    if (op == sqep_pkg::OpSetTarget) begin
      if (num < 1 || num > NServo) return;
      s = num - 1;
      goal = map_angle(ang);
      diff = (goal > s_cur[s]) ? 32'(goal - s_cur[s]) : 32'(s_cur[s] - goal);
      dur = (diff * 32'(r_rate)) >> 8;
      if (dur < r_mine) dur = 32'(r_mine);
      s_dur[s] = dur;
      s_org[s] = s_cur[s];
      s_goal[s] = goal;
      s_t0[s] = now;
      s_moving[s] = 1'b1;
      return;
    end
    cnt = 0;
    for (int i = 0; i < NServo; i++) begin
      if (!s_moving[i]) continue;
      el = now - s_t0[i];
      if (el >= s_dur[i]) begin
        s_cur[i] = s_goal[i];
        s_moving[i] = 1'b0;
      end else begin
        s_cur[i] = eased(i, el);
      end
      r.idx = 1'(i);
      r.pulse = s_cur[i];
      r.last = 1'b0;
      pulse_q.push_back(r);
      cnt++;
    end
    if (cnt > 0) pulse_q[pulse_q.size() - 1].last = 1'b1;
  endtask

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > MaxCycles) begin
      $display("tb_servo_quintic_easing_profile: errors");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    pulse_res_t e;
    if (rst_ni && result_valid_o) begin
      n_res++;
      if (pulse_q.size() == 0) begin
        report($sformatf("unexpected result servo %0d pulse %0d",
                         servo_index_o, pulse_us_o));
      end else begin
        e = pulse_q.pop_front();
        if (servo_index_o !== e.idx)
          report($sformatf("servo index %0d, want %0d", servo_index_o, e.idx));
        if (pulse_us_o !== e.pulse)
          report($sformatf("pulse %0d, want %0d", pulse_us_o, e.pulse));
        if (last_o !== e.last)
          report($sformatf("last %0b, want %0b", last_o, e.last));
      end
    end
  end

  task automatic send_request(input logic op, input logic [1:0] num,
                              input logic [15:0] ang, input logic [31:0] now);
    if ($urandom_range(99) < idle_pct) begin
      start_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < idle_pct);
    end
    start_i <= 1'b1;
    opcode_i <= op;
    servo_number_i <= num;
    target_angle_i <= ang;
    now_ms_i <= now;
    do @(posedge clk_i); while (busy_o);
    predict_request(op, num, ang, now);
    n_req++;
  endtask

  task automatic drain();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (pulse_q.size() != 0 || busy_o) @(posedge clk_i);
    repeat (600) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      sqep_pkg::RegPulseMin: r_pmin = val;
      sqep_pkg::RegPulseMax: r_pmax = val;
      sqep_pkg::RegAngleMax: r_amax = val;
      sqep_pkg::RegMsPerUs:  r_rate = val;
      sqep_pkg::RegMinEase:  r_mine = val;
      default: ;
    endcase
  endtask

  task automatic set_regs(input logic [15:0] pmin, input logic [15:0] pmax,
                          input logic [15:0] amax, input logic [15:0] rate,
                          input logic [15:0] mine);
    drain();
    write_reg(sqep_pkg::RegPulseMin, pmin);
    write_reg(sqep_pkg::RegPulseMax, pmax);
    write_reg(sqep_pkg::RegAngleMax, amax);
    write_reg(sqep_pkg::RegMsPerUs, rate);
    write_reg(sqep_pkg::RegMinEase, mine);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic update_at(input logic [31:0] now);
    send_request(sqep_pkg::OpUpdate, 2'($urandom), 16'($urandom), now);
  endtask

  task automatic test_directed();
    clock_ms = 32'd1000;
    update_at(clock_ms);
    send_request(sqep_pkg::OpSetTarget, 2'd0, 16'd900, clock_ms);
    send_request(sqep_pkg::OpSetTarget, 2'd3, 16'd900, clock_ms);
    update_at(clock_ms + 5);
    send_request(sqep_pkg::OpSetTarget, 2'd1, 16'd0, clock_ms);
    send_request(sqep_pkg::OpSetTarget, 2'd2, 16'hFFFF, clock_ms);
    for (int k = 1; k <= 6; k++) update_at(clock_ms + 32'(k * 180));
    update_at(clock_ms + 2000);
    update_at(clock_ms + 3000);
    set_regs(16'd0, 16'hFFFF, 16'd1, 16'hFFFF, 16'hFFFF);
    send_request(sqep_pkg::OpSetTarget, 2'd1, 16'd1, 32'hFFFF_FF00);
    update_at(32'h0000_0100);
    update_at(32'hFFFF_FF00);
    set_regs(16'd2000, 16'd1000, 16'd0, 16'd0, 16'd0);
    send_request(sqep_pkg::OpSetTarget, 2'd1, 16'd500, 32'd10);
    send_request(sqep_pkg::OpSetTarget, 2'd2, 16'd500, 32'd10);
    update_at(32'd10);
    update_at(32'd11);
  endtask

  task automatic test_random(input int n_items);
    int t;
    logic [1:0] num;
    for (int k = 0; k < n_items; k++) begin
      t = $urandom_range(99);
      if (t < 30) begin
        num = ($urandom_range(9) == 0) ? 2'($urandom_range(3)) * 2'd3 / 2'd3
                                       : 2'($urandom_range(2, 1));
        if ($urandom_range(9) == 0) num = 2'($urandom) & 2'b10 | 2'($urandom) & 2'b01;
        send_request(sqep_pkg::OpSetTarget, num, ($urandom_range(4) == 0) ?
                     16'($urandom) : 16'($urandom_range(r_amax)), clock_ms);
      end else begin
        clock_ms = clock_ms + (($urandom_range(19) == 0) ? $urandom :
                               32'($urandom_range(40)));
        update_at(clock_ms);
      end
    end
  endtask

  task automatic test_settings();
    set_regs(16'd500, 16'd2500, 16'd2700, 16'd256, 16'd50);
    clock_ms = $urandom;
    idle_pct = 0;
    test_random(300);
    set_regs(16'($urandom), 16'($urandom), 16'($urandom_range(65535, 1)),
             16'($urandom_range(1024)), 16'($urandom_range(200)));
    idle_pct = 54;
    test_random(300);
    set_regs(16'd1000, 16'd2000, 16'd1800, 16'd64, 16'd0);
    idle_pct = 31;
    test_random(350);
    set_regs(16'd0, 16'hFFFF, 16'hFFFF, 16'd3, 16'd20);
    idle_pct = 0;
    test_random(330);
  endtask

  initial begin
    r_pmin = 16'd500;
    r_pmax = 16'd2500;
    r_amax = 16'd2700;
    r_rate = 16'd256;
    r_mine = 16'd50;
    for (int i = 0; i < NServo; i++) begin
      s_moving[i] = 1'b0;
      s_cur[i] = sqep_pkg::CentrePulse;
      s_org[i] = sqep_pkg::CentrePulse;
      s_goal[i] = sqep_pkg::CentrePulse;
      s_t0[i] = '0;
      s_dur[i] = '0;
    end
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_settings();
    drain();
    $display("Sent %0d requests over several register settings and three idle levels;",
             n_req);
    $display("checked %0d pulse results, %0d mismatches.", n_res, n_err);
    if (n_err == 0 && pulse_q.size() == 0) begin
      $display("tb_servo_quintic_easing_profile: clean");
    end else begin
      $display("tb_servo_quintic_easing_profile: errors");
    end
    $finish;
  end

endmodule
